[sv/bkfi_pkg.sv]
package bkfi_pkg;

  // field widths of the request and result channels
  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 12;
  localparam int COUNT_W  = 13;

  // request op codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_CREATED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

endpackage

[sv/bkfi_in_if.sv]
interface bkfi_in_if;
  logic                          valid;
  logic                          ready;
  logic [bkfi_pkg::OP_W-1:0]     op;
  logic [bkfi_pkg::KEY_W-1:0]    key_id;

  modport source (output valid, output op, output key_id, input ready);
  modport sink   (input valid, input op, input key_id, output ready);
endinterface

[sv/bkfi_out_if.sv]
interface bkfi_out_if;
  logic                          valid;
  logic                          ready;
  bkfi_pkg::status_t             status;
  logic [bkfi_pkg::SLOT_W-1:0]   slot;
  logic [bkfi_pkg::COUNT_W-1:0]  element_count;

  modport source (output valid, output status, output slot, output element_count,
                  input ready);
  modport sink   (input valid, input status, input slot, input element_count,
                  output ready);
endinterface

[sv/bkfi_store.sv]
// Key words (one per slot) and valid rows (one per bucket).
// Single address per memory; read data registered.
module bkfi_store #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic                        clk,
  input  logic [$clog2(BUCKETS*WAYS)-1:0] key_addr,
  input  logic                        key_we,
  input  logic [bkfi_pkg::KEY_W-1:0]  key_wd,
  output logic [bkfi_pkg::KEY_W-1:0]  key_q,
  input  logic [$clog2(BUCKETS)-1:0]  row_addr,
  input  logic                        row_we,
  input  logic [WAYS-1:0]             row_wd,
  output logic [WAYS-1:0]             row_q
);

  localparam int SLOTS = BUCKETS * WAYS;

  logic [bkfi_pkg::KEY_W-1:0] key_mem [SLOTS];
  logic [WAYS-1:0]            row_mem [BUCKETS];

  // key word memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_addr] <= key_wd;
    end
    key_q <= key_mem[key_addr];
  end

  // valid row memory
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_addr] <= row_wd;
    end
    row_q <= row_mem[row_addr];
  end

endmodule

[sv/bucketed_key_find_or_insert.sv]
// Channel   Dir  Fields                          Handshake
// in_ch     in   op, key_id                      valid/ready, request on both high
// out_ch    out  status, slot, element_count     valid/ready, request on both high
//
// Lookup / find-or-insert: one row read, then one way per cycle through the shared
// 64-bit key comparator, then the result; a hit ends the scan early. BUCKETS is a
// power of two, so the bucket is the low key bits. Clear: one valid row zeroed per
// cycle, then the result. Op code 3 goes straight to its result (not found).
// After reset a sweep clears the valid rows; in_ch.ready stays low.
// A finished result waits in the output register; a new request is taken meanwhile,
// and its result holds the sequencer until that register is free.
module bucketed_key_find_or_insert #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  bkfi_in_if.sink    in_ch,
  bkfi_out_if.source out_ch
);

  localparam int  SLOTS = BUCKETS * WAYS;
  localparam int  BW    = $clog2(BUCKETS);
  localparam int  SW    = $clog2(SLOTS);
  localparam int  WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int  CW    = $clog2(SLOTS + 1);
  localparam bit  POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

  // bucket index is taken from the low key bits
  if (!POW2) begin : g_buckets_check
    $error("BUCKETS must be a power of two");
  end

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_SCAN = 6'b001000,
    S_CLR  = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [bkfi_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [bkfi_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [BW-1:0]                bucket_r, bucket_nxt;
  logic [WW-1:0]                way_r, way_nxt;
  logic [BW-1:0]                clr_row_r, clr_row_nxt;
  logic [CW-1:0]                held_r, held_nxt;
  bkfi_pkg::status_t            res_status_r, res_status_nxt;
  logic [SW-1:0]                res_slot_r, res_slot_nxt;
  logic                         out_valid_r, out_valid_nxt;
  bkfi_pkg::status_t            out_status_r, out_status_nxt;
  logic [SW-1:0]                out_slot_r, out_slot_nxt;
  logic [CW-1:0]                out_count_r, out_count_nxt;

  logic [SW-1:0]                key_addr;
  logic                         key_we;
  logic [bkfi_pkg::KEY_W-1:0]   key_q;
  logic [BW-1:0]                row_addr;
  logic                         row_we;
  logic [WAYS-1:0]              row_wd;
  logic [WAYS-1:0]              row_q;

  logic                         in_acc;
  logic                         fin_ok;
  logic [SW-1:0]                slot_base;
  logic                         hit;
  logic [WW-1:0]                free_way;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign fin_ok = !out_valid_r || out_ch.ready;

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.slot          = bkfi_pkg::SLOT_W'(out_slot_r);
  assign out_ch.element_count = bkfi_pkg::COUNT_W'(out_count_r);

  // first slot of the bucket
  assign slot_base = SW'(SW'(bucket_r) * SW'(WAYS));

  // shared key comparator on the way just read
  assign hit = row_q[way_r] && (key_q == key_r);

  // lowest free way of the row
  always_comb begin
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!row_q[i]) begin
        free_way = WW'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    bucket_nxt     = bucket_r;
    way_nxt        = way_r;
    clr_row_nxt    = clr_row_r;
    held_nxt       = held_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    key_addr       = SW'(slot_base + SW'(way_r) + 1'b1);
    key_we         = 1'b0;
    row_addr       = bucket_r;
    row_we         = 1'b0;
    row_wd         = row_q;

    case (state_r)
      S_INIT, S_CLR: begin
        row_addr    = clr_row_r;
        row_we      = 1'b1;
        row_wd      = '0;
        if (clr_row_r == BW'(BUCKETS - 1)) begin
          if (state_r == S_INIT) begin
            state_nxt = S_IDLE;
          end else begin
            res_status_nxt = bkfi_pkg::ST_CLEARED;
            res_slot_nxt   = '0;
            state_nxt      = S_RESP;
          end
        end else begin
          clr_row_nxt = BW'(clr_row_r + 1'b1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_ch.op;
          key_nxt = in_ch.key_id;
          if (in_ch.op == bkfi_pkg::OP_CLEAR) begin
            held_nxt    = '0;
            clr_row_nxt = '0;
            state_nxt   = S_CLR;
          end else if (in_ch.op != bkfi_pkg::OP_LOOKUP &&
                       in_ch.op != bkfi_pkg::OP_INSERT) begin
            res_status_nxt = bkfi_pkg::ST_NOT_FOUND;
            res_slot_nxt   = '0;
            state_nxt      = S_RESP;
          end else begin
            bucket_nxt = in_ch.key_id[BW-1:0];
            state_nxt  = S_RD;
          end
        end
      end

      S_RD: begin
        key_addr  = slot_base;
        way_nxt   = '0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        if (hit) begin
          res_status_nxt = bkfi_pkg::ST_FOUND;
          res_slot_nxt   = SW'(slot_base + SW'(way_r));
          state_nxt      = S_RESP;
        end else if (way_r == WW'(WAYS - 1)) begin
          state_nxt    = S_RESP;
          res_slot_nxt = '0;
          if (op_r == bkfi_pkg::OP_LOOKUP) begin
            res_status_nxt = bkfi_pkg::ST_NOT_FOUND;
          end else if (&row_q) begin
            res_status_nxt = bkfi_pkg::ST_FULL;
          end else begin
            // take the lowest free way
            key_addr       = SW'(slot_base + SW'(free_way));
            key_we         = 1'b1;
            row_we         = 1'b1;
            row_wd         = row_q | (WAYS'(1) << free_way);
            held_nxt       = CW'(held_r + 1'b1);
            res_status_nxt = bkfi_pkg::ST_CREATED;
            res_slot_nxt   = SW'(slot_base + SW'(free_way));
          end
        end else begin
          way_nxt = WW'(way_r + 1'b1);
        end
      end

      S_RESP: begin
        if (fin_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_count_nxt  = held_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_row_r   <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    bucket_r     <= bucket_nxt;
    way_r        <= way_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  bkfi_store #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_store (
    .clk      (clk),
    .key_addr (key_addr),
    .key_we   (key_we),
    .key_wd   (key_r),
    .key_q    (key_q),
    .row_addr (row_addr),
    .row_we   (row_we),
    .row_wd   (row_wd),
    .row_q    (row_q)
  );

  // count never exceeds the number of slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(SLOTS))
    else $error("element count above slot total");

  // an insert write adds exactly one element
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |=> held_r == CW'($past(held_r) + 1'b1))
    else $error("insert did not bump element count");

  // an accepted clear request zeroes the element count at once
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.op == bkfi_pkg::OP_CLEAR) |=> held_r == '0)
    else $error("clear left elements counted");

  // results without a slot report slot zero
  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != bkfi_pkg::ST_FOUND &&
     out_status_r != bkfi_pkg::ST_CREATED) |-> out_slot_r == '0)
    else $error("slot set on a result without a slot");

endmodule
